// File: sv/rse_pkg.sv
package rse_pkg;

  localparam int DATA_W = 32;
  localparam int STACK_DEPTH_DEFAULT = 256;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_AND = 4'd4,
    OP_OR  = 4'd5,
    OP_XOR = 4'd6
  } op_code_t;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] number;
    logic [3:0]         op_code;
    logic               is_last;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               result_valid;
  } out_t;

endpackage

// File: sv/rse_stack_mem.sv
module rse_stack_mem #(
  parameter int DEPTH = rse_pkg::STACK_DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [rse_pkg::DATA_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [rse_pkg::DATA_W-1:0] rd_data
);

  logic [rse_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/rse_divider.sv
module rse_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rse_pkg::DATA_W-1:0] dividend,
  input  logic [rse_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [rse_pkg::DATA_W-1:0] quotient
);

  localparam int W  = rse_pkg::DATA_W;
  localparam int SW = $clog2(W);

  logic          busy;
  logic [SW-1:0] step;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dmag;
  logic          neg;
  logic          zero;
  logic [W:0]    rem_shift;
  logic [W:0]    diff;

  assign rem_shift = {rem, quo[W-1]};
  assign diff      = rem_shift - {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= '0;
        quo  <= dividend[W-1] ? (W'(0) - dividend) : dividend;
        dmag <= divisor[W-1] ? (W'(0) - divisor) : divisor;
        neg  <= dividend[W-1] ^ divisor[W-1];
        zero <= (divisor == '0);
      end else if (busy) begin
        if (!diff[W]) begin
          rem <= diff[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= rem_shift[W-1:0];
          quo <= {quo[W-2:0], 1'b0};
        end
        step <= step + SW'(1);
        if (step == SW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = zero ? '0 : (neg ? (W'(0) - quo) : quo);

endmodule

// File: sv/rpn_stack_evaluator_core.sv
// Postfix expression evaluator on a signed 32-bit operand stack.
// Input channel tok_valid/tok_ready/tok carries one token per transaction:
// a number (mode 0) or an operator (mode 1), is_last closing the expression.
// Output channel res_valid/res_ready/res carries one transaction for each
// token with is_last set: the popped top of stack and a flag that is low
// when the stack was empty. The stack is empty again after that transaction.
// Work per token, beginning with the accept:
//   number, or operator with fewer than two operands or an unused code: nothing further;
//   operator other than divide: two stack reads, then write;
//   divide: two stack reads, the radix-2 divider that takes 32 iterations, then write;
//   a last token adds the final stack read and result load.
// The stack lives in a single memory with one write and one registered
// read port; operands are read one per cycle.
// Reset empties the stack and drops any pending result; memory contents
// are not cleared.
// The result register holds a waiting transaction while the next tokens are
// taken; a last token whose result finds that register still full waits
// until res_ready frees it, and tok_ready stays low meanwhile.
module rpn_stack_evaluator_core #(
  parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          tok_valid,
  output logic          tok_ready,
  input  rse_pkg::in_t  tok,
  output logic          res_valid,
  input  logic          res_ready,
  output rse_pkg::out_t res
);

  localparam int W  = rse_pkg::DATA_W;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_RD_A    = 6'b000010,
    S_RD_B    = 6'b000100,
    S_DIV     = 6'b001000,
    S_FIN_RD  = 6'b010000,
    S_FIN_OUT = 6'b100000
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     cnt_m2;
  logic              last;
  rse_pkg::op_code_t op;
  logic [W-1:0]      opa;
  logic [W-1:0]      alu_res;

  logic              tok_acc;
  logic              full;
  logic              op_ok;
  logic              out_free;

  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [W-1:0]      mem_wr_data;
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [W-1:0]      mem_rd_data;

  logic              div_start;
  logic              div_done;
  logic [W-1:0]      div_q;

  assign cnt_m1    = count - CW'(1);
  assign cnt_m2    = count - CW'(2);
  assign full      = (count == CW'(STACK_DEPTH));
  assign op_ok     = (tok.op_code <= rse_pkg::OP_XOR);
  assign tok_ready = (state == S_IDLE);
  assign tok_acc   = tok_valid && tok_ready;
  assign out_free  = !res_valid || res_ready;

  always_comb begin
    case (op)
      rse_pkg::OP_ADD: alu_res = mem_rd_data + opa;
      rse_pkg::OP_SUB: alu_res = mem_rd_data - opa;
      rse_pkg::OP_MUL: alu_res = W'(mem_rd_data * opa);
      rse_pkg::OP_AND: alu_res = mem_rd_data & opa;
      rse_pkg::OP_OR:  alu_res = mem_rd_data | opa;
      rse_pkg::OP_XOR: alu_res = mem_rd_data ^ opa;
      default:         alu_res = '0;
    endcase
  end

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = cnt_m2[AW-1:0];
    mem_wr_data = alu_res;
    mem_rd_en   = 1'b0;
    mem_rd_addr = cnt_m1[AW-1:0];
    div_start   = 1'b0;
    case (state)
      S_IDLE: begin
        if (tok_acc) begin
          if (!tok.mode) begin
            mem_wr_en   = !full;
            mem_wr_addr = count[AW-1:0];
            mem_wr_data = tok.number;
          end else if (op_ok && count >= CW'(2)) begin
            mem_rd_en = 1'b1;
          end
        end
      end
      S_RD_A: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = cnt_m2[AW-1:0];
      end
      S_RD_B: begin
        if (op == rse_pkg::OP_DIV) begin
          div_start = 1'b1;
        end else begin
          mem_wr_en = 1'b1;
        end
      end
      S_DIV: begin
        mem_wr_en   = div_done;
        mem_wr_data = div_q;
      end
      S_FIN_RD: begin
        mem_rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && state != S_FIN_OUT) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (tok_acc) begin
            last <= tok.is_last;
            op   <= rse_pkg::op_code_t'(tok.op_code);
            if (!tok.mode) begin
              if (!full) begin
                count <= count + CW'(1);
              end
              state <= tok.is_last ? S_FIN_RD : S_IDLE;
            end else if (op_ok && count >= CW'(2)) begin
              state <= S_RD_A;
            end else begin
              if (op_ok && count == CW'(1)) begin
                count <= '0;
              end
              state <= tok.is_last ? S_FIN_RD : S_IDLE;
            end
          end
        end
        S_RD_A: begin
          opa   <= mem_rd_data;
          state <= S_RD_B;
        end
        S_RD_B: begin
          if (op == rse_pkg::OP_DIV) begin
            state <= S_DIV;
          end else begin
            count <= cnt_m1;
            state <= last ? S_FIN_RD : S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            count <= cnt_m1;
            state <= last ? S_FIN_RD : S_IDLE;
          end
        end
        S_FIN_RD: begin
          state <= S_FIN_OUT;
        end
        S_FIN_OUT: begin
          if (out_free) begin
            res_valid        <= 1'b1;
            res.result_valid <= (count != '0);
            res.result_value <= (count != '0) ? mem_rd_data : '0;
            count            <= '0;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  rse_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  rse_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mem_rd_data),
    .divisor  (opa),
    .done     (div_done),
    .quotient (div_q)
  );

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_operands_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_A || state == S_RD_B || state == S_DIV) |-> count >= CW'(2))
    else $error("operator in progress without two operands");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside divide state");

  a_final_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN_OUT && out_free) |=> (count == '0 && state == S_IDLE && res_valid))
    else $error("result load did not empty the stack");

  a_push_in_range: assert property (@(posedge clk) disable iff (rst)
    (mem_wr_en && state == S_IDLE) |-> !full)
    else $error("push written to a full stack");
`endif

endmodule
